// ----- hdl/svpd_pkg.sv -----
// shared types, codes and constants for the stepper valve position drive
// no dependencies; imported by stepper_valve_position_drive
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_PRESET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_ENABLED       = 2'd0,
    REG_NORMAL_OPEN   = 2'd1,
    REG_STEP_INTERVAL = 2'd2,
    REG_OPEN_OVERRUN  = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned POS_W      = 16;

  localparam logic [7:0]       STEP_MAX         = 8'd205;
  localparam logic [7:0]       STEP_MIN         = 8'd20;
  localparam logic [POS_W-1:0] HOME_PULSES      = 16'd780;
  localparam logic [POS_W-1:0] HALL_MARGIN      = 16'd40;
  localparam logic [POS_W-1:0] OVERRUN_CAP      = 16'd300;
  localparam logic [7:0]       STEP_INTERVAL_RST = 8'd15;

  // 1-2 phase (half step) coil pattern: bit0 X1, bit1 X2, bit2 Y1, bit3 Y2
  function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
    logic [3:0] c;
    case (phase)
      3'd0:    c = 4'h5;
      3'd1:    c = 4'h4;
      3'd2:    c = 4'h6;
      3'd3:    c = 4'h2;
      3'd4:    c = 4'hA;
      3'd5:    c = 4'h8;
      3'd6:    c = 4'h9;
      default: c = 4'h1;
    endcase
    return c;
  endfunction

  // step count times 26 pulses, by shifts and adds
  function automatic logic [POS_W-1:0] steps_to_pulses(input logic [7:0] steps);
    logic [POS_W-1:0] s;
    s = {8'd0, steps};
    return (s << 4) + (s << 3) + (s << 1);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/stepper_valve_position_drive.sv -----
// half-step stepper valve position drive: top level
// depends on svpd_pkg for op codes, register indexes, constants and the coil table
`timescale 1ns / 1ps
`default_nettype none

// Positions a valve stepper in half steps. Items are ticks, move commands and
// position presets; each item gives exactly one result (coils, position, running,
// command_taken). One item is taken every clock cycle when the output side keeps
// up: an item lands in the input register, its whole state update is worked out
// in one pass of logic, and the result register is loaded from it once the
// result register is free or is being emptied. Configuration registers are
// written through cfg_write/cfg_index/cfg_data and should only change while no
// item is in flight.
module stepper_valve_position_drive (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [svpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [1:0]                        op,
  input  wire logic [7:0]                        step_command,
  input  wire logic [svpd_pkg::POS_W-1:0]        preset_value,
  input  wire logic                              hall_active,
  // output channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [3:0]                        coils,
  output      logic [svpd_pkg::POS_W-1:0]        position,
  output      logic                              running,
  output      logic                              command_taken
);

  import svpd_pkg::*;

  // configuration registers
  logic       enabled;
  logic       normal_open;
  logic [7:0] step_interval;
  logic [7:0] open_overrun;

  // input register
  logic             item_valid;
  logic [1:0]       item_op;
  logic [7:0]       item_step;
  logic [POS_W-1:0] item_preset;
  logic             item_hall;

  // drive state
  logic [POS_W-1:0] cur_position,        cur_position_next;
  logic [POS_W-1:0] target_position,     target_position_next;
  logic [POS_W-1:0] close_overrun_count, close_overrun_count_next;
  logic [7:0]       pending_backoff,     pending_backoff_next;
  logic [POS_W-1:0] overrun_limit,       overrun_limit_next;
  logic [POS_W-1:0] origin_position,     origin_position_next;
  logic             seen_origin,         seen_origin_next;
  logic [2:0]       coil_phase,          coil_phase_next;
  logic             busy,                busy_next;
  logic [7:0]       tick_countdown,      tick_countdown_next;
  logic [3:0]       coil_state,          coil_state_next;
  logic             taken_next;

  logic advance;
  logic in_take;

  logic [7:0]       req_clamped;
  logic [POS_W-1:0] goal;
  logic [POS_W-1:0] teach_lim;
  logic [POS_W-1:0] pos_dec;

  // result register is free, or its transfer happens this edge
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (item_step > STEP_MAX) begin
      req_clamped = STEP_MAX;
    end else if (item_step < STEP_MIN) begin
      req_clamped = 8'd0;
    end else begin
      req_clamped = item_step;
    end
    goal      = steps_to_pulses(req_clamped);
    teach_lim = origin_position - HALL_MARGIN;
    pos_dec   = cur_position - 16'd1;
  end

  always_comb begin
    cur_position_next        = cur_position;
    target_position_next     = target_position;
    close_overrun_count_next = close_overrun_count;
    pending_backoff_next     = pending_backoff;
    overrun_limit_next       = overrun_limit;
    origin_position_next     = origin_position;
    seen_origin_next         = seen_origin;
    coil_phase_next          = coil_phase;
    busy_next                = busy;
    tick_countdown_next      = tick_countdown;
    coil_state_next          = coil_state;
    taken_next               = 1'b0;

    unique case (item_op)
      OP_TICK: begin
        if (tick_countdown != 8'd0) begin
          tick_countdown_next = tick_countdown - 8'd1;
        end else if (enabled) begin
          tick_countdown_next = step_interval;
          if (!busy) begin
            coil_state_next = 4'h0;
          end else if (target_position > cur_position) begin
            // opening half step, teach the overrun limit from the hall sensor
            cur_position_next = cur_position + 16'd1;
            coil_phase_next   = normal_open ? coil_phase - 3'd1 : coil_phase + 3'd1;
            coil_state_next   = half_step_coils(coil_phase_next);
            if (item_hall) begin
              origin_position_next = cur_position + 16'd1;
              seen_origin_next     = 1'b1;
            end else if (seen_origin) begin
              overrun_limit_next = (teach_lim > OVERRUN_CAP) ? OVERRUN_CAP : teach_lim;
            end
          end else if (target_position < cur_position) begin
            if (item_hall && (close_overrun_count >= overrun_limit)) begin
              close_overrun_count_next = '0;
              cur_position_next        = '0;
              target_position_next     = '0;
              coil_state_next          = 4'h0;
              busy_next                = 1'b0;
            end else begin
              if (item_hall) begin
                close_overrun_count_next = close_overrun_count + 16'd1;
              end
              cur_position_next = pos_dec;
              coil_phase_next   = normal_open ? coil_phase + 3'd1 : coil_phase - 3'd1;
              if (pos_dec == '0) begin
                close_overrun_count_next = '0;
                target_position_next     = '0;
                coil_state_next          = 4'h0;
                busy_next                = 1'b0;
              end else begin
                coil_state_next = half_step_coils(coil_phase_next);
              end
            end
          end else if ((target_position != '0) && (pending_backoff != 8'd0)) begin
            // overshoot done, back off to the real target
            target_position_next = target_position - {8'd0, pending_backoff};
            pending_backoff_next = 8'd0;
          end else begin
            close_overrun_count_next = '0;
            coil_state_next          = 4'h0;
            busy_next                = 1'b0;
          end
        end
      end
      OP_MOVE: begin
        if (!busy && (cur_position != goal)) begin
          taken_next          = 1'b1;
          busy_next           = 1'b1;
          tick_countdown_next = step_interval;
          if (goal == '0) begin
            // homing runs past the mechanical origin
            cur_position_next        = cur_position + HOME_PULSES;
            close_overrun_count_next = '0;
            target_position_next     = '0;
          end else if (cur_position >= goal) begin
            close_overrun_count_next = '0;
            pending_backoff_next     = 8'd0;
            target_position_next     = goal;
          end else begin
            pending_backoff_next = open_overrun;
            target_position_next = goal + {8'd0, open_overrun};
          end
        end
      end
      OP_PRESET: begin
        cur_position_next = item_preset;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b1;
      normal_open   <= 1'b0;
      step_interval <= STEP_INTERVAL_RST;
      open_overrun  <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLED:       enabled       <= cfg_data[0];
        REG_NORMAL_OPEN:   normal_open   <= cfg_data[0];
        REG_STEP_INTERVAL: step_interval <= cfg_data;
        REG_OPEN_OVERRUN:  open_overrun  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_op     <= op;
      item_step   <= step_command;
      item_preset <= preset_value;
      item_hall   <= hall_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_position        <= '0;
      target_position     <= '0;
      close_overrun_count <= '0;
      pending_backoff     <= 8'd0;
      overrun_limit       <= OVERRUN_CAP;
      origin_position     <= '0;
      seen_origin         <= 1'b0;
      coil_phase          <= 3'd0;
      busy                <= 1'b0;
      tick_countdown      <= 8'd0;
      coil_state          <= 4'h0;
    end else if (advance) begin
      cur_position        <= cur_position_next;
      target_position     <= target_position_next;
      close_overrun_count <= close_overrun_count_next;
      pending_backoff     <= pending_backoff_next;
      overrun_limit       <= overrun_limit_next;
      origin_position     <= origin_position_next;
      seen_origin         <= seen_origin_next;
      coil_phase          <= coil_phase_next;
      busy                <= busy_next;
      tick_countdown      <= tick_countdown_next;
      coil_state          <= coil_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      coils         <= coil_state_next;
      position      <= cur_position_next;
      running       <= busy_next;
      command_taken <= taken_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/valve_drive_checker.sv -----
// result checker for the stepper valve position drive: follows every transfer,
// keeps its own copy of the drive state and compares each result with it
// depends on svpd_pkg for op codes, register indexes and drive constants
`timescale 1ns / 1ps

module valve_drive_checker
  import svpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [1:0]            op,
  input  wire logic [7:0]            step_command,
  input  wire logic [POS_W-1:0]      preset_value,
  input  wire logic                  hall_active,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [3:0]            coils,
  input  wire logic [POS_W-1:0]      position,
  input  wire logic                  running,
  input  wire logic                  command_taken,
  output int                         failures,
  output int                         delivered,
  output int                         backlog
);

  localparam logic [POS_W-1:0] PULSES_PER_STEP = 16'd26;
  // half step coil patterns, phase 0 in the low nibble
  localparam logic [31:0] COIL_SEQ = {4'h1, 4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5};

  typedef struct packed {
    logic [3:0]       coils;
    logic [POS_W-1:0] position;
    logic             running;
    logic             taken;
  } valve_out_t;

  // register copies
  logic             en_r, nopen_r;
  logic [7:0]       interval_r, overrun_r;
  // drive state
  logic [POS_W-1:0] pos_r, goal_r, close_over_r, limit_r, origin_r;
  logic [7:0]       backoff_r, countdown_r;
  logic             seen_r, busy_r;
  logic [2:0]       phase_r;
  logic [3:0]       coil_r;

  valve_out_t awaited_outputs[$];
  int fail_count = 0;
  int done_count = 0;
  int queued     = 0;

  assign failures  = fail_count;
  assign delivered = done_count;
  assign backlog   = queued;

  function automatic void check_field(input string what, input logic [POS_W-1:0] want,
                                      input logic [POS_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function automatic void stop_motor();
    coil_r = '0;
    busy_r = 1'b0;
  endfunction

  function automatic void arrive_home();
    close_over_r = '0;
    pos_r        = '0;
    goal_r       = '0;
    stop_motor();
  endfunction

  function automatic void shift_one(input logic closing);
    logic up;
    if (closing) begin
      pos_r = pos_r - 16'd1;
      up    = nopen_r;
    end else begin
      pos_r = pos_r + 16'd1;
      up    = !nopen_r;
    end
    phase_r = up ? phase_r + 3'd1 : phase_r - 3'd1;
  endfunction

  function automatic void half_step(input logic closing, input logic hall);
    logic [POS_W-1:0] lim;
    if (closing) begin
      if (pos_r != '0) shift_one(1'b1);
      if (pos_r == '0) arrive_home();
    end else begin
      shift_one(1'b0);
      // opening run teaches where the origin sensor sits
      if (hall) begin
        origin_r = pos_r;
        seen_r   = 1'b1;
      end else if (seen_r) begin
        lim     = origin_r - HALL_MARGIN;
        limit_r = (lim > OVERRUN_CAP) ? OVERRUN_CAP : lim;
      end
    end
    if (busy_r) coil_r = COIL_SEQ[{phase_r, 2'b00} +: 4];
  endfunction

  function automatic valve_out_t advance_valve(input logic [1:0] kind, input logic [7:0] cmd,
                                              input logic [POS_W-1:0] pre, input logic hall);
    logic [7:0]       req;
    logic [POS_W-1:0] aim;
    logic             taken;
    valve_out_t       res;
    taken = 1'b0;
    case (kind)
      OP_TICK: begin
        if (countdown_r != '0) begin
          countdown_r = countdown_r - 8'd1;
        end else if (en_r) begin
          if (!busy_r) begin
            stop_motor();
          end else if (goal_r > pos_r) begin
            half_step(1'b0, hall);
          end else if (goal_r < pos_r) begin
            // closing past the origin gives up after the learned overrun
            if (hall && close_over_r >= limit_r) begin
              arrive_home();
            end else begin
              if (hall) close_over_r = close_over_r + 16'd1;
              half_step(1'b1, hall);
            end
          end else if (goal_r != '0 && backoff_r != '0) begin
            goal_r    = goal_r - {8'd0, backoff_r};
            backoff_r = '0;
          end else begin
            close_over_r = '0;
            stop_motor();
          end
          countdown_r = interval_r;
        end
      end
      OP_MOVE: begin
        req = cmd;
        if (req > STEP_MAX) req = STEP_MAX;
        if (req < STEP_MIN) req = '0;
        aim = {8'd0, req} * PULSES_PER_STEP;
        if (!busy_r && pos_r != aim) begin
          if (aim == '0) begin
            // homing starts well beyond the origin, wrapping if need be
            pos_r        = pos_r + HOME_PULSES;
            close_over_r = '0;
            goal_r       = '0;
          end else begin
            if (pos_r >= aim) begin
              close_over_r = '0;
              backoff_r    = '0;
            end else begin
              backoff_r = overrun_r;
            end
            goal_r = aim + {8'd0, backoff_r};
          end
          busy_r      = 1'b1;
          countdown_r = interval_r;
          taken       = 1'b1;
        end
      end
      OP_PRESET: pos_r = pre;
      default: ;
    endcase
    res.coils    = coil_r;
    res.position = pos_r;
    res.running  = busy_r;
    res.taken    = taken;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    valve_out_t want, got;
    if (rst) begin
      en_r         = 1'b1;
      nopen_r      = 1'b0;
      interval_r   = STEP_INTERVAL_RST;
      overrun_r    = '0;
      pos_r        = '0;
      goal_r       = '0;
      close_over_r = '0;
      backoff_r    = '0;
      limit_r      = OVERRUN_CAP;
      origin_r     = '0;
      seen_r       = 1'b0;
      phase_r      = '0;
      busy_r       = 1'b0;
      countdown_r  = '0;
      coil_r       = '0;
      awaited_outputs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLED:       en_r       = cfg_data[0];
          REG_NORMAL_OPEN:   nopen_r    = cfg_data[0];
          REG_STEP_INTERVAL: interval_r = cfg_data;
          REG_OPEN_OVERRUN:  overrun_r  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {coils, position, running, command_taken};
        if (awaited_outputs.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual position %0d", $time, position);
        end else begin
          want = awaited_outputs.pop_front();
          check_field("coils", POS_W'(want.coils), POS_W'(got.coils));
          check_field("position", want.position, got.position);
          check_field("running", POS_W'(want.running), POS_W'(got.running));
          check_field("command_taken", POS_W'(want.taken), POS_W'(got.taken));
        end
        done_count <= done_count + 1;
      end
      if (in_valid && !in_stall)
        awaited_outputs.push_back(advance_valve(op, step_command, preset_value, hall_active));
    end
    queued <= awaited_outputs.size();
  end

endmodule

// ----- verif/tb.sv -----
// testbench top for the stepper valve position drive: clock, reset, register
// set-up, stimulus and verdict; results are judged by valve_drive_checker
// depends on svpd_pkg, stepper_valve_position_drive and valve_drive_checker
`timescale 1ns / 1ps

module tb;
  import svpd_pkg::*;

  localparam logic [POS_W-1:0] PULSES_PER_STEP = 16'd26;
  localparam logic [1:0]       OP_SPARE        = 2'd3;
  localparam int               QUIET_LIMIT     = 2000;
  localparam int               HOLD_CYCLES     = 150;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [1:0]            cfg_index    = REG_ENABLED;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            op           = OP_TICK;
  logic [7:0]            step_command = '0;
  logic [POS_W-1:0]      preset_value = '0;
  logic                  hall_active  = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [3:0]            coils;
  logic [POS_W-1:0]      position;
  logic                  running;
  logic                  command_taken;

  int failures, delivered, backlog;
  int sent_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet          = 0;
  int cur_iv         = 15;
  int cur_ov         = 0;
  int tick_stop      = 32'h7FFF_FFFF;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stepper_valve_position_drive i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .step_command(step_command),
    .preset_value(preset_value), .hall_active(hall_active),
    .out_valid(out_valid), .out_stall(out_stall), .coils(coils), .position(position),
    .running(running), .command_taken(command_taken)
  );

  valve_drive_checker i_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .step_command(step_command),
    .preset_value(preset_value), .hall_active(hall_active),
    .out_valid(out_valid), .out_stall(out_stall), .coils(coils), .position(position),
    .running(running), .command_taken(command_taken),
    .failures(failures), .delivered(delivered), .backlog(backlog)
  );

  // receiver: random stall, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] cmd,
                           input logic [POS_W-1:0] pre, input logic hall);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    step_command <= cmd;
    preset_value <= pre;
    hall_active  <= hall;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic nopen, input logic [7:0] iv,
                            input logic [7:0] ov);
    put_reg(REG_ENABLED, {7'd0, en});
    put_reg(REG_NORMAL_OPEN, {7'd0, nopen});
    put_reg(REG_STEP_INTERVAL, iv);
    put_reg(REG_OPEN_OVERRUN, ov);
    cfg_write <= 1'b0;
    cur_iv = int'(iv);
    cur_ov = int'(ov);
  endtask

  // hold the sender until every result is back, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    wait (delivered == sent_count);
    repeat (4) @(posedge clk);
  endtask

  // ticks stop once the phase has used its share of items
  task automatic tick_run(input int n, input int hall_pct);
    repeat (n) begin
      if (sent_count < tick_stop)
        send_item(OP_TICK, 8'($urandom), POS_W'($urandom), $urandom_range(99) < hall_pct);
    end
  endtask

  // preset close to the goal so the move completes in a handful of steps
  task automatic move_run();
    logic [7:0]       stepc, eff;
    logic [POS_W-1:0] aim;
    int               offs, span, n, hall_pct;
    hall_pct = 30 * $urandom_range(2);
    stepc = ($urandom_range(99) < 15) ? 8'($urandom) : 8'($urandom_range(205, 20));
    eff = (stepc > STEP_MAX) ? STEP_MAX : stepc;
    if (eff < STEP_MIN) eff = '0;
    aim  = {8'd0, eff} * PULSES_PER_STEP;
    offs = int'($urandom_range(50)) - 25;
    span = (offs < 0) ? -offs : offs;
    send_item(OP_PRESET, 8'($urandom), aim + POS_W'(offs), 1'($urandom));
    send_item(OP_MOVE, stepc, POS_W'($urandom), 1'($urandom));
    if ($urandom_range(99) < 30) begin
      // detour near the origin so the opening run learns a new overrun limit
      send_item(OP_PRESET, 8'($urandom), POS_W'($urandom_range(90)), 1'($urandom));
      n = $urandom_range(6, 1) * (cur_iv + 1);
      tick_run((n > 40) ? 40 : n, 50);
      send_item(OP_PRESET, 8'($urandom), aim - POS_W'($urandom_range(10)), 1'($urandom));
    end
    n = (span + 2 * cur_ov + 4) * (cur_iv + 1);
    tick_run((n > 600) ? 600 : n, hall_pct);
  endtask

  task automatic home_run();
    logic [POS_W-1:0] start;
    int               pick, n;
    pick = $urandom_range(9);
    // half the starts wrap to a short run once the homing lead is added
    if (pick < 5) start = POS_W'($urandom_range(40)) - HOME_PULSES;
    else if (pick < 8) start = POS_W'($urandom_range(60, 1));
    else start = POS_W'($urandom);
    send_item(OP_PRESET, 8'($urandom), start, 1'($urandom));
    send_item(OP_MOVE, 8'($urandom_range(19)), POS_W'($urandom), 1'($urandom));
    if ($urandom_range(1))
      send_item(OP_PRESET, 8'($urandom), POS_W'($urandom_range(40, 1)), 1'($urandom));
    n = 70 * (cur_iv + 1);
    tick_run((n > 600) ? 600 : n, 60);
  endtask

  task automatic noise_run();
    repeat ($urandom_range(6, 1))
      send_item(2'($urandom_range(3)), 8'($urandom), POS_W'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(input logic en, input logic nopen, input logic [7:0] iv,
                           input logic [7:0] ov, input int idle, input int stall,
                           input int budget, input bit squeeze);
    int first, pick;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    set_config(en, nopen, iv, ov);
    if (squeeze) hold_asks++;
    first     = sent_count;
    tick_stop = first + budget;
    while (sent_count - first < budget) begin
      pick = $urandom_range(9);
      if (pick < 6) move_run();
      else if (pick < 8) home_run();
      else noise_run();
    end
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b1, 1'b0, 8'd0, 8'd3);
    send_item(OP_TICK, 8'd0, 16'h0000, 1'b0);
    send_item(OP_SPARE, 8'hFF, 16'hFFFF, 1'b1);
    send_item(OP_MOVE, 8'd0, 16'h0000, 1'b0);              // already at home
    send_item(OP_PRESET, 8'hFF, 16'hFFFF, 1'b1);
    send_item(OP_PRESET, 8'd0, 16'h0000, 1'b0);
    send_item(OP_PRESET, 8'd0, {8'd0, STEP_MAX} * PULSES_PER_STEP - 16'd1, 1'b0);
    send_item(OP_MOVE, 8'hFF, 16'h0000, 1'b0);             // clamps to the top step
    send_item(OP_MOVE, 8'd19, 16'h0000, 1'b0);             // busy, so dropped
    tick_run(9, 0);                                        // overshoot, back off, stop
    send_item(OP_PRESET, 8'd0, POS_W'(4) - HOME_PULSES, 1'b0);
    send_item(OP_MOVE, 8'd19, 16'h0000, 1'b0);             // homing lead wraps round
    tick_run(5, 0);
    settle();

    run_phase(1'b1, 1'b0, 8'd0,   8'd0,   0,  0,  250, 1'b1);
    run_phase(1'b1, 1'b1, 8'd1,   8'd7,   52, 0,  250, 1'b0);
    run_phase(1'b1, 1'b0, 8'd0,   8'd255, 0,  52, 220, 1'b0);
    run_phase(1'b0, 1'b1, 8'd0,   8'd2,   19, 19, 100, 1'b0);
    run_phase(1'b1, 1'b1, 8'd255, 8'd0,   0,  0,  150, 1'b0);
    run_phase(1'b1, 1'b0, 8'd2,   8'd1,   52, 0,  200, 1'b0);
    run_phase(1'b1, 1'b1, 8'd0,   8'd12,  0,  52, 280, 1'b1);
    run_phase(1'b1, 1'b0, 8'd1,   8'd0,   19, 19, 280, 1'b0);

    if (failures == 0 && backlog == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
